FILE: rtl/core/erb_pkg.sv
`timescale 1ns / 1ps
// Package for the ERB band compressor: transaction structs, the sequencer
// state type, fixed widths and the output rounding function. No dependencies.
package erb_pkg;

	localparam int WADDR_W  = 14;
	localparam int WMEM_DEP = 16384;
	localparam int WIDX_W   = 15;
	localparam int BAND_W   = 6;
	localparam int POS_W    = 9;
	localparam int ACC_W    = 48;
	localparam int PROD_W   = 40;

	typedef struct packed {
		logic                      operation;
		logic [WADDR_W-1:0]        weight_address;
		logic signed [15:0]        weight_value;
		logic signed [23:0]        sample;
	} erb_in_t;

	typedef struct packed {
		logic signed [23:0] value;
		logic [7:0]         band_index;
		logic               last;
	} erb_out_t;

	// Weight memory write port.
	typedef struct packed {
		logic               vld;
		logic [WADDR_W-1:0] addr;
		logic signed [15:0] data;
	} erb_wr_t;

	// One multiply-accumulate issue; band also addresses the accumulator read.
	typedef struct packed {
		logic              vld;
		logic              first;
		logic [BAND_W-1:0] band;
		logic [WIDX_W-1:0] widx;
	} erb_mac_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PASS,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_WT
	} erb_state_t;

	// Round half up from Q.30 to Q8.15, then saturate to 24 bits.
	function automatic logic signed [23:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		logic signed [32:0]      q;
		t = acc + 48'sd16384;
		q = t[ACC_W-1:15];
		if (q > 33'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (q < -33'sd8388608) begin
			return 24'sh800000;
		end else begin
			return q[23:0];
		end
	endfunction

endpackage

FILE: rtl/core/erb_mac_unit.sv
`timescale 1ns / 1ps
// Weight memory, band accumulator memory and the shared multiply-accumulate
// pipeline of the ERB band compressor. Depends on erb_pkg.
module erb_mac_unit #(
	parameter int BANDS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  erb_pkg::erb_wr_t                  wr,
	input  erb_pkg::erb_mac_req_t             req,
	input  logic signed [23:0]                sample,
	output logic signed [erb_pkg::ACC_W-1:0]  rd_data,
	output logic                              busy
);
	import erb_pkg::*;

	localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

	logic signed [15:0]      wmem [WMEM_DEP];
	logic signed [ACC_W-1:0] amem [BANDS];

	logic signed [15:0]      wrd_q;
	logic signed [ACC_W-1:0] ard_q;

	logic              vld_s1, first_s1, zw_s1;
	logic [BW-1:0]     band_s1;
	logic              vld_s2, first_s2;
	logic [BW-1:0]     band_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s2;

	logic signed [15:0]       w_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  sum_s2;

	always_ff @(posedge clk) begin
		if (wr.vld) begin
			wmem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		wrd_q <= wmem[req.widx[WADDR_W-1:0]];
		ard_q <= amem[req.band[BW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= req.first;
		zw_s1    <= req.widx[WIDX_W-1];
		band_s1  <= req.band[BW-1:0];
		first_s2 <= first_s1;
		band_s2  <= band_s1;
		prod_s2  <= prod_s1;
		acc_s2   <= ard_q;
	end

	// An index beyond the weight memory reads as a zero weight.
	assign w_s1    = zw_s1 ? 16'sd0 : wrd_q;
	assign prod_s1 = sample * w_s1;

	// The first high bin of a row overwrites, which also clears the sums.
	assign sum_s2 = first_s2 ? {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2}
	                         : acc_s2 + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			amem[band_s2] <= sum_s2;
		end
	end

	assign rd_data = ard_q;
	assign busy    = vld_s1 | vld_s2;

endmodule

FILE: rtl/core/erb_band_compress.sv
`timescale 1ns / 1ps
// ERB band compressor top level. A weight load leaves the sequencer idle, a
// pass-through bin waits for a free output register, a high bin makes one MAC
// issue per band and waits for the pipeline to drain; the last bin of a row then
// emits the band sums. One item is worked on at a time; the sequencer sets this.
// Reset clears the sequencer and bin counter; weights are undefined until loaded.
module erb_band_compress #(
	parameter int PASS_BINS = 65,
	parameter int BANDS     = 64,
	parameter int ROW_BINS  = 257
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  erb_pkg::erb_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output erb_pkg::erb_out_t result
);
	import erb_pkg::*;

	localparam int HIGH_BINS = (ROW_BINS > PASS_BINS) ? ROW_BINS - PASS_BINS : 1;

	erb_state_t state_q, state_d;

	logic [POS_W-1:0]  pos_q;
	logic [BAND_W-1:0] band_q;
	logic [WIDX_W-1:0] widx_q;
	logic              first_q, row_end_q;
	logic signed [23:0] sample_q;
	erb_out_t          pass_q;
	erb_out_t          result_q;
	logic              result_vld_q;

	logic              accept, is_sample, row_end, is_pass, last_band, out_free, out_load;
	erb_out_t          out_d;
	erb_wr_t           wr;
	erb_mac_req_t      req;
	logic signed [ACC_W-1:0] rd_data;
	logic              busy;

	assign accept    = item_valid && item_ready;
	assign is_sample = item.operation;
	assign row_end   = (pos_q == POS_W'(ROW_BINS - 1));
	assign is_pass   = ({1'b0, pos_q} < (POS_W+1)'(PASS_BINS));
	assign last_band = (band_q == BAND_W'(BANDS - 1));
	assign out_free  = !result_vld_q || result_ready;

	erb_mac_unit #(
		.BANDS(BANDS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.req    (req),
		.sample (sample_q),
		.rd_data(rd_data),
		.busy   (busy)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_sample) begin
					state_d = is_pass ? ST_PASS : ST_MAC;
				end
			end
			ST_PASS: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_MAC: begin
				if (last_band) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!busy) begin
					state_d = row_end_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WT;
			end
			ST_EMIT_WT: begin
				if (out_free) begin
					state_d = last_band ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		item_ready = (state_q == ST_IDLE);
		wr.vld     = accept && !is_sample;
		wr.addr    = item.weight_address;
		wr.data    = item.weight_value;
		req.vld    = (state_q == ST_MAC);
		req.first  = first_q;
		req.band   = band_q;
		req.widx   = widx_q;
		out_load   = 1'b0;
		out_d      = pass_q;
		case (state_q)
			ST_PASS: begin
				out_load = out_free;
			end
			ST_EMIT_WT: begin
				out_load         = out_free;
				out_d.value      = round_sat(rd_data);
				out_d.band_index = 8'(PASS_BINS + int'(band_q));
				out_d.last       = last_band;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			band_q       <= '0;
			result_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && is_sample) begin
				pos_q  <= row_end ? '0 : pos_q + POS_W'(1);
				band_q <= '0;
			end else if (state_q == ST_MAC) begin
				band_q <= last_band ? '0 : band_q + BAND_W'(1);
			end else if (state_q == ST_EMIT_WT && out_free && !last_band) begin
				band_q <= band_q + BAND_W'(1);
			end
			if (out_load) begin
				result_vld_q <= 1'b1;
			end else if (result_ready) begin
				result_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_sample) begin
			row_end_q         <= row_end;
			sample_q          <= item.sample;
			first_q           <= (pos_q == POS_W'(PASS_BINS));
			widx_q            <= WIDX_W'(pos_q - POS_W'(PASS_BINS));
			pass_q.value      <= item.sample;
			pass_q.band_index <= pos_q[7:0];
			pass_q.last       <= row_end;
		end else if (state_q == ST_MAC) begin
			widx_q <= widx_q + WIDX_W'(HIGH_BINS);
		end
		if (out_load) begin
			result_q <= out_d;
		end
	end

	assign result_valid = result_vld_q;
	assign result       = result_q;

	// A new transaction is only taken once every accumulator write has landed.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !busy)
		else $error("item taken while the MAC pipeline is busy");

	a_emit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_WT) |-> !busy)
		else $error("band sum read while a write is pending");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(ROW_BINS - 1))
		else $error("bin counter beyond the row");

	a_mac_band_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC && last_band) |=> (state_q == ST_DRAIN && band_q == '0))
		else $error("band counter not rewound after the last MAC issue");

endmodule
